### sv/rcae_pkg.sv
// ============================================================================
// rcae_pkg - shared constants and types for the rule condition/action engine
// Item field widths, operation and relation codes, and the flag bundle that
// the datapath hands back to the control logic.
// ============================================================================
package rcae_pkg;

    // Fixed field widths of the streaming items
    localparam int OP_W    = 3;
    localparam int INDEX_W = 9;
    localparam int CODE_W  = 3;
    localparam int DATA_W  = 32;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_PROPERTIES = 512;
    localparam int DEF_VALUE_WIDTH    = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
    localparam logic [OP_W-1:0] OP_COND   = 3'd1;
    localparam logic [OP_W-1:0] OP_ACTION = 3'd2;
    localparam logic [OP_W-1:0] OP_APPLY  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // Relation codes for condition items
    localparam logic [CODE_W-1:0] REL_EQ = 3'd1;
    localparam logic [CODE_W-1:0] REL_GT = 3'd2;
    localparam logic [CODE_W-1:0] REL_LT = 3'd3;
    localparam logic [CODE_W-1:0] REL_GE = 3'd4;
    localparam logic [CODE_W-1:0] REL_LE = 3'd5;
    localparam logic [CODE_W-1:0] REL_NE = 3'd6;

    // Action codes
    localparam logic [CODE_W-1:0] ACT_ADD     = 3'd1;
    localparam logic [CODE_W-1:0] ACT_SUB     = 3'd2;
    localparam logic [CODE_W-1:0] ACT_ADD_ALT = 3'd3;

    // Datapath outcome flags for one item
    typedef struct packed {
        logic prop_we;
        logic delta_we;
        logic met;
        logic pass;
    } alu_flags_t;

endpackage

### sv/rcae_store.sv
// ============================================================================
// rcae_store - single-port-write, single-port-read synchronous value store
// One write and one registered read per cycle; read data holds when idle.
// ============================================================================
module rcae_store
    import rcae_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_PROPERTIES,
    parameter int WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/rcae_alu.sv
// ============================================================================
// rcae_alu - compare, saturating add and result selection for one item
// Works on extended signed values so no intermediate sum can wrap.
// ============================================================================
module rcae_alu
    import rcae_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic [OP_W-1:0]        operation,
    input  logic [CODE_W-1:0]      code,
    input  logic [DATA_W-1:0]      operand_value,
    input  logic [VALUE_WIDTH-1:0] prop,
    input  logic [VALUE_WIDTH-1:0] delta,
    input  logic                   ok,
    input  logic                   pass_in,
    output logic [DATA_W-1:0]      result_value,
    output logic [VALUE_WIDTH-1:0] prop_wdata,
    output logic [VALUE_WIDTH-1:0] delta_wdata,
    output alu_flags_t             flags
);

    localparam int W  = VALUE_WIDTH;
    localparam int EW = ((W > DATA_W) ? W : DATA_W) + 2;

    localparam logic signed [EW-1:0] MAX_E = EW'($signed({1'b0, {(W-1){1'b1}}}));
    localparam logic signed [EW-1:0] MIN_E = EW'($signed({1'b1, {(W-1){1'b0}}}));

    function automatic logic [W-1:0] clamp(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] c;
        if (v > MAX_E)
            c = MAX_E;
        else if (v < MIN_E)
            c = MIN_E;
        else
            c = v;
        return c[W-1:0];
    endfunction

    logic signed [EW-1:0] p_e;
    logic signed [EW-1:0] d_e;
    logic signed [EW-1:0] v_e;
    logic signed [EW-1:0] add_a;
    logic signed [EW-1:0] add_b;
    logic [W-1:0]         sum_c;
    logic                 rel_eq;
    logic                 rel_gt;
    logic                 rel_lt;
    logic                 met;
    logic [W-1:0]         res_w;
    logic signed [EW-1:0] res_e;

    // entries beyond the store read as zero
    assign p_e = ok ? EW'($signed(prop))  : '0;
    assign d_e = ok ? EW'($signed(delta)) : '0;
    assign v_e = EW'($signed(operand_value));

    assign rel_eq = (p_e == v_e);
    assign rel_gt = (p_e > v_e);
    assign rel_lt = (p_e < v_e);

    always_comb
    begin
        unique case (code)
            REL_EQ:  met = rel_eq;
            REL_GT:  met = rel_gt;
            REL_LT:  met = rel_lt;
            REL_GE:  met = !rel_lt;
            REL_LE:  met = !rel_gt;
            REL_NE:  met = !rel_eq;
            default: met = 1'b0;
        endcase
    end

    // one shared adder: delta +/- amount for actions, property + delta for apply
    always_comb
    begin
        if (operation == OP_ACTION)
        begin
            add_a = d_e;
            add_b = (code == ACT_SUB) ? -v_e : v_e;
        end
        else
        begin
            add_a = p_e;
            add_b = d_e;
        end
    end

    assign sum_c = clamp(add_a + add_b);

    always_comb
    begin
        res_w       = '0;
        prop_wdata  = sum_c;
        delta_wdata = '0;
        flags       = '{prop_we: 1'b0, delta_we: 1'b0, met: 1'b0, pass: pass_in};
        unique case (operation)
            OP_WRITE:
            begin
                prop_wdata    = clamp(v_e);
                res_w         = ok ? prop_wdata : '0;
                flags.prop_we = ok;
            end
            OP_COND:
            begin
                res_w      = p_e[W-1:0];
                flags.met  = met;
                flags.pass = pass_in && met;
            end
            OP_ACTION:
            begin
                res_w = d_e[W-1:0];
                if (ok && pass_in &&
                    (code == ACT_ADD || code == ACT_ADD_ALT || code == ACT_SUB))
                begin
                    res_w          = sum_c;
                    delta_wdata    = sum_c;
                    flags.delta_we = 1'b1;
                end
            end
            OP_APPLY:
            begin
                res_w          = ok ? sum_c : '0;
                flags.prop_we  = ok;
                flags.delta_we = ok;
            end
            OP_READ:
            begin
                res_w = p_e[W-1:0];
            end
            default:
            begin
                res_w = '0;
            end
        endcase
    end

    assign res_e        = EW'($signed(res_w));
    assign result_value = res_e[DATA_W-1:0];

endmodule

### sv/rule_condition_action_engine.sv
// ============================================================================
// rule_condition_action_engine - property/delta rule evaluator
// Streams rule-list items against a property store and a delta store held in
// synchronous memories; one result beat per input beat.
// ============================================================================
//
//  channel   | dir | beat contents
//  ----------+-----+--------------------------------------------------------
//  s_axis    | in  | tuser: operation, new_list; tdata: index, code, operand
//  m_axis    | out | tdata: result_value, condition_met, list_active
//
//  Sequence: the accept cycle issues the read of both stores, and the
//  execute state then computes and writes back; no new item is accepted
//  until the current one leaves the execute state.
//  Reset: after rst_n releases, both stores are zeroed one entry per cycle,
//  with s_axis_tready low until the last entry is cleared.
//  Stalls: a result waits in the output register; the next item is accepted
//  while it waits and holds in the execute cycle, with s_axis_tready low
//  until the waiting result leaves.
//
module rule_condition_action_engine
    import rcae_pkg::*;
#(
    parameter int NUM_PROPERTIES = DEF_NUM_PROPERTIES,
    parameter int VALUE_WIDTH    = DEF_VALUE_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // index[8:0], code[11:9], operand_value[43:12], 0
    input  logic [3:0]  s_axis_tuser,  // operation[2:0], new_list[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result_value[31:0], condition_met[32],
                                       // list_active[33], 0
);

    localparam int AW   = $clog2(NUM_PROPERTIES);
    localparam int CMPW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PROPERTIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          pass_reg, pass_next;

    // captured item
    logic [OP_W-1:0]   op_reg;
    logic              nl_reg;
    logic [AW-1:0]     addr_reg;
    logic              ok_reg;
    logic [CODE_W-1:0] code_reg;
    logic [DATA_W-1:0] opv_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [39:0]       out_data_reg;

    // input field unpack
    logic [INDEX_W-1:0] in_index;
    logic [CODE_W-1:0]  in_code;
    logic [DATA_W-1:0]  in_opv;
    logic               accept;
    logic               go;

    // store ports
    logic                   prop_we, delta_we;
    logic [AW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] prop_wd, delta_wd;
    logic [VALUE_WIDTH-1:0] prop_rd, delta_rd;

    // datapath
    logic [DATA_W-1:0]      alu_res;
    logic [VALUE_WIDTH-1:0] alu_prop_wd, alu_delta_wd;
    alu_flags_t             alu_flags;

    assign in_index = s_axis_tdata[8:0];
    assign in_code  = s_axis_tdata[11:9];
    assign in_opv   = s_axis_tdata[43:12];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // execute only when the output register can take the result
    assign go            = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        pass_next = pass_reg;
        if (go)
            pass_next = alu_flags.pass;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pass_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item capture and result register: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_axis_tuser[2:0];
            nl_reg   <= s_axis_tuser[3];
            addr_reg <= AW'(in_index);
            ok_reg   <= (CMPW'(in_index) < CMPW'(NUM_PROPERTIES));
            code_reg <= in_code;
            opv_reg  <= in_opv;
        end
        if (go)
        begin
            out_data_reg <= {6'b0, alu_flags.pass, alu_flags.met, alu_res};
        end
    end

    // write port: zero sweep after reset, otherwise the item's write-back
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            prop_we  = 1'b1;
            delta_we = 1'b1;
            waddr    = clr_cnt_reg;
            prop_wd  = '0;
            delta_wd = '0;
        end
        else
        begin
            prop_we  = go && alu_flags.prop_we;
            delta_we = go && alu_flags.delta_we;
            waddr    = addr_reg;
            prop_wd  = alu_prop_wd;
            delta_wd = alu_delta_wd;
        end
    end

    rcae_store #(
        .DEPTH (NUM_PROPERTIES),
        .WIDTH (VALUE_WIDTH)
    ) u_prop_store (
        .clk   (clk),
        .we    (prop_we),
        .waddr (waddr),
        .wdata (prop_wd),
        .re    (accept),
        .raddr (AW'(in_index)),
        .rdata (prop_rd)
    );

    rcae_store #(
        .DEPTH (NUM_PROPERTIES),
        .WIDTH (VALUE_WIDTH)
    ) u_delta_store (
        .clk   (clk),
        .we    (delta_we),
        .waddr (waddr),
        .wdata (delta_wd),
        .re    (accept),
        .raddr (AW'(in_index)),
        .rdata (delta_rd)
    );

    // new_list sets the flag before the item is evaluated
    rcae_alu #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_alu (
        .operation     (op_reg),
        .code          (code_reg),
        .operand_value (opv_reg),
        .prop          (prop_rd),
        .delta         (delta_rd),
        .ok            (ok_reg),
        .pass_in       (pass_reg || nl_reg),
        .result_value  (alu_res),
        .prop_wdata    (alu_prop_wd),
        .delta_wdata   (alu_delta_wd),
        .flags         (alu_flags)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during store clear");

    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted item did not enter execute");

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (prop_we || delta_we) |-> (state_reg == ST_CLEAR || state_reg == ST_EXEC))
        else $error("store write outside clear or execute");

    a_no_write_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && !ok_reg) |-> (!prop_we && !delta_we))
        else $error("store write for an index beyond the store");

    a_go_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> m_axis_tvalid)
        else $error("executed item left no result beat");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for rule_condition_action_engine
// Drives rule-list beats on s_axis and mirrors the property/delta stores in a
// local model. Each accepted input beat queues one expected result, and each
// m_axis beat is checked field by field against the oldest entry. Both sides
// idle at random, and the receiver also holds off for a long stretch.
// ============================================================================
module tb;
    import rcae_pkg::*;

    localparam int     NUM_ENTRIES  = DEF_NUM_PROPERTIES;
    localparam longint Q_MAX        = 2147483647;
    localparam longint Q_MIN        = -Q_MAX - 1;
    // no accepted beat on either side for this many cycles ends the run;
    // covers the store clearing after reset and the long receiver hold-off
    localparam int     STALL_LIMIT  = 5000;
    localparam int     HOLD_CYCLES  = 250;
    localparam int     TAIL_CYCLES  = 8;

    // one input item, fields at the block's widths
    typedef struct {
        logic [OP_W-1:0]           operation;
        logic                      new_list;
        logic [INDEX_W-1:0]        index;
        logic [CODE_W-1:0]         code;
        logic signed [DATA_W-1:0]  operand;
    } rule_item_t;

    // one expected result beat
    typedef struct {
        logic signed [DATA_W-1:0]  value;
        logic                      met;
        logic                      active;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // index[8:0], code[11:9], operand_value[43:12], 0
    logic [3:0]  s_axis_tuser = '0;   // operation[2:0], new_list[3]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // result_value[31:0], condition_met[32],
                                      // list_active[33], 0

    // local copy of the block state
    logic signed [DATA_W-1:0] property_mem [NUM_ENTRIES];
    logic signed [DATA_W-1:0] delta_mem [NUM_ENTRIES];
    bit                       list_pass = 1'b1;

    outcome_t pending_outcomes [$];

    int error_count   = 0;
    int result_beats  = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 15;
    int hold_left     = 0;

    rule_condition_action_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            property_mem[i] = '0;
            delta_mem[i]    = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Model of the engine
    // ------------------------------------------------------------------------
    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // Updates the local stores for one accepted item and returns its result.
    function automatic outcome_t apply_rule_item(input rule_item_t it);
        outcome_t o;
        bit       hit;
        longint   prop;
        longint   opv;
        longint   acc;
        hit     = (int'(it.index) < NUM_ENTRIES);
        prop    = hit ? longint'(property_mem[it.index]) : 0;
        opv     = longint'(it.operand);
        o.value = '0;
        o.met   = 1'b0;
        // new_list raises the pass flag before the item itself is evaluated
        if (it.new_list)
            list_pass = 1'b1;
        case (it.operation)
            OP_WRITE:
            begin
                if (hit)
                begin
                    property_mem[it.index] = it.operand;
                    o.value = it.operand;
                end
            end
            OP_COND:
            begin
                case (it.code)
                    REL_EQ:  o.met = (prop == opv);
                    REL_GT:  o.met = (prop >  opv);
                    REL_LT:  o.met = (prop <  opv);
                    REL_GE:  o.met = (prop >= opv);
                    REL_LE:  o.met = (prop <= opv);
                    REL_NE:  o.met = (prop != opv);
                    default: o.met = 1'b0;   // unknown relation never holds
                endcase
                if (!o.met)
                    list_pass = 1'b0;
                o.value = prop[31:0];
            end
            OP_ACTION:
            begin
                if (hit)
                begin
                    acc = longint'(delta_mem[it.index]);
                    // inert while the list has failed or for unknown codes
                    if (list_pass)
                    begin
                        if (it.code == ACT_ADD || it.code == ACT_ADD_ALT)
                            acc = clamp_q(acc + opv);
                        else if (it.code == ACT_SUB)
                            acc = clamp_q(acc - opv);
                        delta_mem[it.index] = acc[31:0];
                    end
                    o.value = acc[31:0];
                end
            end
            OP_APPLY:
            begin
                if (hit)
                begin
                    acc = clamp_q(prop + longint'(delta_mem[it.index]));
                    property_mem[it.index] = acc[31:0];
                    delta_mem[it.index]    = '0;
                    o.value = acc[31:0];
                end
            end
            OP_READ:
                o.value = prop[31:0];
            default:
                o.value = '0;   // unknown operation: only the new_list effect
        endcase
        o.active = list_pass;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic rule_item_t rule_item(input logic [OP_W-1:0] op, input logic nl,
                                             input int idx, input logic [CODE_W-1:0] code,
                                             input logic [DATA_W-1:0] val);
        rule_item_t it;
        it.operation = op;
        it.new_list  = nl;
        it.index     = idx[INDEX_W-1:0];
        it.code      = code;
        it.operand   = val;
        return it;
    endfunction

    // Offers one beat after a random idle gap; the model is updated on the
    // edge where the beat is taken. tvalid stays high into the next call so
    // back-to-back beats never see a low/high pair in one time step.
    task automatic send_item(input rule_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.operand, it.code, it.index};
        s_axis_tuser  <= {it.new_list, it.operation};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_outcomes.push_back(apply_rule_item(it));
    endtask

    // mostly a small hot set so conditions and applies hit entries with history
    function automatic int pick_index();
        if ($urandom_range(0, 99) < 75)
            return $urandom_range(0, 15);
        return $urandom_range(0, NUM_ENTRIES - 1);
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand(input int idx);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return property_mem[idx];
        if (r < 45)
            return property_mem[idx] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        if (r < 60)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 85)
            return $urandom_range(0, 32'h10_0000) - 32'h8_0000;   // within +/-0x8_0000
        return $urandom;
    endfunction

    function automatic logic [CODE_W-1:0] pick_relation();
        if ($urandom_range(0, 99) < 92)
            return CODE_W'($urandom_range(REL_EQ, REL_NE));
        return $urandom_range(0, 1) ? 3'd7 : 3'd0;
    endfunction

    function automatic logic [CODE_W-1:0] pick_action();
        int c;
        if ($urandom_range(0, 99) < 85)
            return CODE_W'($urandom_range(ACT_ADD, ACT_ADD_ALT));
        c = $urandom_range(4, 8);
        return (c == 8) ? 3'd0 : c[CODE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Extremes, each relation, each action, saturation both ways, unknown
    // relation and action codes, actions on a failed list, unknown operations.
    task automatic test_directed();
        send_item(rule_item(OP_WRITE,  1'b0, 0,   3'd0,    32'h7FFF_FFFF));
        send_item(rule_item(OP_WRITE,  1'b0, 511, 3'd0,    32'h8000_0000));
        send_item(rule_item(OP_READ,   1'b0, 0,   3'd0,    32'h0));
        send_item(rule_item(OP_READ,   1'b0, 511, 3'd0,    32'h0));
        send_item(rule_item(OP_COND,   1'b1, 0,   REL_EQ,  32'h7FFF_FFFF));
        send_item(rule_item(OP_COND,   1'b0, 511, REL_GT,  32'h8000_0000));
        // list has failed: this action must leave the delta alone
        send_item(rule_item(OP_ACTION, 1'b0, 0,   ACT_ADD, 32'd5));
        send_item(rule_item(OP_COND,   1'b1, 511, REL_LT,  32'h0));
        send_item(rule_item(OP_COND,   1'b0, 511, REL_GE,  32'h8000_0000));
        send_item(rule_item(OP_COND,   1'b0, 0,   REL_LE,  32'h7FFF_FFFF));
        send_item(rule_item(OP_COND,   1'b0, 0,   REL_NE,  32'h0));
        send_item(rule_item(OP_ACTION, 1'b0, 0,   ACT_ADD, 32'h7FFF_FFFF));
        send_item(rule_item(OP_ACTION, 1'b0, 0,   ACT_ADD_ALT, 32'd1));   // clamps high
        send_item(rule_item(OP_APPLY,  1'b0, 0,   3'd0,    32'h0));       // clamps high
        send_item(rule_item(OP_ACTION, 1'b0, 511, ACT_SUB, 32'h8000_0000)); // negate min
        send_item(rule_item(OP_ACTION, 1'b0, 511, ACT_SUB, 32'd1));
        send_item(rule_item(OP_ACTION, 1'b0, 511, 3'd0,    32'd77));
        send_item(rule_item(OP_ACTION, 1'b0, 511, 3'd7,    32'd77));
        send_item(rule_item(OP_APPLY,  1'b0, 511, 3'd0,    32'h0));
        send_item(rule_item(OP_ACTION, 1'b1, 511, ACT_ADD, 32'h8000_0000));
        send_item(rule_item(OP_APPLY,  1'b0, 511, 3'd0,    32'h0));       // clamps low
        send_item(rule_item(OP_COND,   1'b1, 0,   3'd0,    32'h7FFF_FFFF));
        send_item(rule_item(OP_COND,   1'b1, 0,   3'd7,    32'h7FFF_FFFF));
        send_item(rule_item(3'd5,      1'b1, 0,   3'd0,    32'hFFFF_FFFF));
        send_item(rule_item(3'd7,      1'b0, 511, 3'd7,    32'hFFFF_FFFF));
        send_item(rule_item(OP_WRITE,  1'b0, 400, 3'd0,    32'hFFFF_FFFF));
        send_item(rule_item(OP_READ,   1'b0, 400, 3'd0,    32'h0));
    endtask

    // Well-formed lists: conditions first, then actions, sometimes an apply,
    // a property write or a read to move the stored values around.
    task automatic test_rule_lists(input int item_count);
        int sent;
        int idx;
        int last_action;
        sent = 0;
        while (sent < item_count)
        begin
            idx = pick_index();
            send_item(rule_item(OP_COND, 1'b1, idx, pick_relation(), pick_operand(idx)));
            sent++;
            repeat ($urandom_range(0, 2))
            begin
                idx = pick_index();
                send_item(rule_item(OP_COND, 1'b0, idx, pick_relation(), pick_operand(idx)));
                sent++;
            end
            last_action = pick_index();
            repeat ($urandom_range(1, 3))
            begin
                last_action = pick_index();
                send_item(rule_item(OP_ACTION, 1'b0, last_action, pick_action(),
                                    pick_operand(last_action)));
                sent++;
            end
            if ($urandom_range(0, 99) < 35)
            begin
                send_item(rule_item(OP_APPLY, 1'b0, last_action, CODE_W'($urandom),
                                    $urandom));
                sent++;
            end
            if ($urandom_range(0, 99) < 20)
            begin
                idx = pick_index();
                send_item(rule_item(OP_WRITE, 1'b0, idx, CODE_W'($urandom),
                                    pick_operand(idx)));
                sent++;
            end
            if ($urandom_range(0, 99) < 10)
            begin
                send_item(rule_item(OP_READ, 1'b0, pick_index(), CODE_W'($urandom),
                                    $urandom));
                sent++;
            end
        end
    endtask

    // every field fully random, unknown operations included
    task automatic test_noise(input int item_count);
        repeat (item_count)
            send_item(rule_item(OP_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                $urandom_range(0, NUM_ENTRIES - 1),
                                CODE_W'($urandom_range(0, 7)), $urandom));
    endtask

    // receiver stops for a long stretch while lists keep coming, so the
    // output register and execute stage fill and s_axis_tready drops
    task automatic test_back_pressure();
        hold_left = HOLD_CYCLES;
        test_rule_lists(40);
    endtask

    task automatic test_no_idle_stretch();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_rule_lists(250);
        send_idle_pct = 15;
        recv_idle_pct = 15;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus the counted hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int beat,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("beat %0d: %s is %h, expected %h", beat, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected beat, result_value", result_beats,
                                m_axis_tdata[31:0], 32'h0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                    report_mismatch("result_value", result_beats,
                                    m_axis_tdata[31:0], want.value);
                if (m_axis_tdata[32] !== want.met)
                    report_mismatch("condition_met", result_beats,
                                    32'(m_axis_tdata[32]), 32'(want.met));
                if (m_axis_tdata[33] !== want.active)
                    report_mismatch("list_active", result_beats,
                                    32'(m_axis_tdata[33]), 32'(want.active));
            end
            result_beats++;
        end
    end

    // Watchdog: cycles without any accepted beat on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_rule_lists(500);
        test_back_pressure();
        test_no_idle_stretch();
        test_noise(200);
        test_rule_lists(300);
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        // let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
